[hdl/bcsa1_pkg.sv]
// bcsa1_pkg: shared constants for the BLE channel selection #1 hop sequencer.
// No dependencies; used by the top level and its checker.

package bcsa1_pkg;

    localparam int NUM_CHANNELS_DEF = 37;

    localparam int MODE_W  = 2;
    localparam int START_W = 6;
    localparam int IDX_W   = 6;
    localparam int HOP_W   = 5;
    localparam int OP_W    = 7;
    localparam int STEP_W  = 3;

    localparam int S_DATA_W = 8;
    localparam int M_DATA_W = 16;
    localparam int APB_DW   = 64;
    localparam int APB_AW   = 4;

    localparam logic [HOP_W-1:0] HOP_RESET = 5'd5;

    // register select, taken from paddr[3] (registers sit at 0x0 and 0x8)
    localparam logic REG_CHANNEL_MAP   = 1'b0;
    localparam logic REG_HOP_INCREMENT = 1'b1;

    localparam logic [MODE_W-1:0] MODE_ADVANCE = 2'd0;
    localparam logic [MODE_W-1:0] MODE_QUERY   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_ZERO    = 2'd2;
    localparam logic [MODE_W-1:0] MODE_LOAD    = 2'd3;

    typedef enum logic [2:0] {
        ST_REBUILD,
        ST_IDLE,
        ST_MOD_N,
        ST_CHECK,
        ST_MOD_CNT,
        ST_READ,
        ST_RESULT
    } state_t;

endpackage

[hdl/ble_csa1_hop_sequencer.sv]
// Bluetooth LE channel selection algorithm #1 hop sequencer, top level.
// Depends on bcsa1_pkg.

// One beat in gives one beat out. A new input beat is taken only once the
// result of the last one is in the output register. A beat passes ST_MOD_N
// and ST_CHECK, for a remapped index also ST_MOD_CNT and ST_READ, then
// ST_RESULT. The index is wrapped modulo the channel count by
// compare-and-subtract, registered in ST_MOD_N. A remapped index is reduced
// modulo the used count by a bit-serial remainder unit, one dividend bit per
// step, and then the used channel list memory is read via a registered port.
// After reset and after every channel_map write the list is rebuilt by a
// sweep over all NUM_CHANNELS channels, during which s_tready stays low.
// Results wait in an output register, and s_tready returns while a result is
// still held. A finished result waits while the output register holds a beat
// that has not been taken, and no new beat is taken during that time.
module ble_csa1_hop_sequencer
    import bcsa1_pkg::*;
#(
    parameter int NUM_CHANNELS = NUM_CHANNELS_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,   // [1:0] mode, [7:2] start_channel
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata,   // [5:0] channel, [11:6] unmapped_index,
                                           // [12] map_empty, [15:13] zero
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [APB_AW-1:0]   paddr,
    input  logic [APB_DW-1:0]   pwdata,
    output logic [APB_DW-1:0]   prdata,
    output logic                pready
);

    localparam int CH_W  = $clog2(NUM_CHANNELS);
    localparam int CNT_W = $clog2(NUM_CHANNELS + 1);

    state_t state_reg, state_next;

    logic [NUM_CHANNELS-1:0] map_reg;
    logic [HOP_W-1:0]        hop_reg;
    logic [CH_W-1:0]         sweep_reg;
    logic [CNT_W-1:0]        count_reg;
    logic [CH_W-1:0]         unmapped_reg;
    logic [CH_W-1:0]         chan_reg;

    logic [OP_W-1:0]   dvd_reg;
    logic [OP_W-1:0]   rem_reg;
    logic [OP_W-1:0]   dsr_reg;
    logic [STEP_W-1:0] step_reg;
    logic [OP_W:0]     trial;
    logic [OP_W:0]     diff;
    logic [OP_W-1:0]   rem_next;
    logic              div_last;
    logic [OP_W-1:0]   wrapped;

    logic [CH_W-1:0] list_mem [NUM_CHANNELS];
    logic [CH_W-1:0] rd_data_reg;
    logic [CH_W-1:0] rd_addr;
    logic            rd_en;

    logic              m_tvalid_reg;
    logic [M_DATA_W-1:0] m_tdata_reg;

    logic            cfg_wr;
    logic            map_wr;
    logic            hop_wr;
    logic            in_beat;
    logic            out_load;
    logic            map_empty;
    logic            cur_used;
    logic            end_sweep;
    logic [MODE_W-1:0]  in_mode;
    logic [START_W-1:0] in_start;
    logic [OP_W-1:0]    operand;

    // wrap modulo the channel count: compare-and-subtract against the shifted counts
    function automatic logic [OP_W-1:0] wrap_n(input logic [OP_W-1:0] x);
        logic [OP_W-1:0] r;
        r = x;
        for (int k = OP_W - 1; k >= 0; k--)
        begin
            if ((NUM_CHANNELS << k) < (1 << OP_W))
            begin
                if (r >= OP_W'(NUM_CHANNELS << k))
                begin
                    r = r - OP_W'(NUM_CHANNELS << k);
                end
            end
        end
        return r;
    endfunction

    assign pready   = 1'b1;
    assign cfg_wr   = psel & penable & pwrite & pready;
    assign map_wr   = cfg_wr & (paddr[3] == REG_CHANNEL_MAP);
    assign hop_wr   = cfg_wr & (paddr[3] == REG_HOP_INCREMENT);

    assign in_mode  = s_tdata[MODE_W-1:0];
    assign in_start = s_tdata[MODE_W +: START_W];
    assign in_beat  = s_tvalid & s_tready;

    assign map_empty = (count_reg == '0);
    assign cur_used  = map_reg[unmapped_reg];
    assign end_sweep = (sweep_reg == CH_W'(NUM_CHANNELS - 1));

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    assign wrapped  = wrap_n(dvd_reg);

    always_comb
    begin
        unique case (paddr[3])
            REG_CHANNEL_MAP:   prdata = APB_DW'(map_reg);
            REG_HOP_INCREMENT: prdata = APB_DW'(hop_reg);
            default:           prdata = '0;
        endcase
    end

    // restoring remainder, one dividend bit per cycle
    assign trial    = {rem_reg, dvd_reg[OP_W-1]};
    assign diff     = trial - {1'b0, dsr_reg};
    assign rem_next = (trial >= {1'b0, dsr_reg}) ? diff[OP_W-1:0] : trial[OP_W-1:0];
    assign div_last = (step_reg == STEP_W'(OP_W - 1));

    always_comb
    begin
        unique case (in_mode)
            MODE_ADVANCE: operand = OP_W'(unmapped_reg) + OP_W'(hop_reg);
            MODE_QUERY:   operand = OP_W'(unmapped_reg);
            MODE_ZERO:    operand = '0;
            MODE_LOAD:    operand = OP_W'(in_start);
            default:      operand = '0;
        endcase
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        if (map_wr)
        begin
            state_next = ST_REBUILD;
        end
        else
        begin
            unique case (state_reg)
                ST_REBUILD: if (end_sweep) state_next = ST_IDLE;
                ST_IDLE:    if (in_beat) state_next = ST_MOD_N;
                ST_MOD_N:   state_next = ST_CHECK;
                ST_CHECK:   state_next = (cur_used || map_empty) ? ST_RESULT : ST_MOD_CNT;
                ST_MOD_CNT: if (div_last) state_next = ST_READ;
                ST_READ:    state_next = ST_RESULT;
                ST_RESULT:  if (out_load) state_next = ST_IDLE;
                default:    state_next = ST_REBUILD;
            endcase
        end
    end

    // control outputs
    always_comb
    begin
        s_tready = 1'b0;
        out_load = 1'b0;
        rd_en    = 1'b0;
        rd_addr  = rem_next[CH_W-1:0];
        unique case (state_reg)
            ST_IDLE:    s_tready = 1'b1;
            ST_MOD_CNT: rd_en = div_last;
            ST_RESULT:  out_load = ~m_tvalid_reg | m_tready;
            default:    ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_REBUILD;
            map_reg      <= {NUM_CHANNELS{1'b1}};
            hop_reg      <= HOP_RESET;
            sweep_reg    <= '0;
            count_reg    <= '0;
            unmapped_reg <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (map_wr)
            begin
                map_reg   <= pwdata[NUM_CHANNELS-1:0];
                sweep_reg <= '0;
                count_reg <= '0;
            end
            else if (state_reg == ST_REBUILD)
            begin
                sweep_reg <= sweep_reg + 1'b1;
                if (map_reg[sweep_reg])
                begin
                    count_reg <= count_reg + 1'b1;
                end
            end
            if (hop_wr)
            begin
                hop_reg <= pwdata[HOP_W-1:0];
            end
            if (state_reg == ST_MOD_N)
            begin
                unmapped_reg <= wrapped[CH_W-1:0];
            end
            if (out_load)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // datapath, no reset
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            ST_IDLE:
            begin
                dvd_reg  <= operand;
            end
            ST_CHECK:
            begin
                chan_reg <= unmapped_reg;
                dvd_reg  <= OP_W'(unmapped_reg);
                rem_reg  <= '0;
                dsr_reg  <= OP_W'(count_reg);
                step_reg <= '0;
            end
            ST_MOD_CNT:
            begin
                dvd_reg  <= {dvd_reg[OP_W-2:0], 1'b0};
                rem_reg  <= rem_next;
                step_reg <= step_reg + 1'b1;
            end
            ST_READ:
            begin
                chan_reg <= rd_data_reg;
            end
            default: ;
        endcase
        if (out_load)
        begin
            m_tdata_reg <= {3'b000, map_empty, IDX_W'(unmapped_reg), IDX_W'(chan_reg)};
        end
    end

    // used channel list
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_REBUILD && !map_wr && map_reg[sweep_reg])
        begin
            list_mem[count_reg[CH_W-1:0]] <= sweep_reg;
        end
        if (rd_en)
        begin
            rd_data_reg <= list_mem[rd_addr];
        end
    end

endmodule

[hdl/bcsa1_checker.sv]
// bcsa1_checker: port-level assertions for ble_csa1_hop_sequencer.
// Depends on bcsa1_pkg; bound to the top level at the end of this file.

module bcsa1_checker
    import bcsa1_pkg::*;
#(
    parameter int NUM_CHANNELS = NUM_CHANNELS_DEF
)
(
    input logic                clk,
    input logic                rst_n,
    input logic                s_tvalid,
    input logic                s_tready,
    input logic                m_tvalid,
    input logic                m_tready,
    input logic [M_DATA_W-1:0] m_tdata,
    input logic                pready
);

    // one item at a time: no beat taken in the cycle after a beat
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input beat taken back to back");

    a_empty_raw: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tdata[12]) |-> (m_tdata[5:0] == m_tdata[11:6]))
        else $error("empty map but channel differs from unmapped index");

    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> ((m_tdata[5:0] < NUM_CHANNELS) && (m_tdata[11:6] < NUM_CHANNELS)))
        else $error("channel out of range");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("stalled output beat changed");

    a_pready: assert property (@(posedge clk) disable iff (!rst_n)
        pready)
        else $error("pready low");

endmodule

bind ble_csa1_hop_sequencer bcsa1_checker #(.NUM_CHANNELS(NUM_CHANNELS)) u_bcsa1_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .pready   (pready)
);

[dv/testbench.sv]
`timescale 1ns / 100ps
// testbench: self-checking bench for ble_csa1_hop_sequencer (BLE channel selection #1).
// Predicts hop index and remapped data channel per beat; depends on bcsa1_pkg and the RTL.

module testbench;
    import bcsa1_pkg::*;

    localparam int NCH         = NUM_CHANNELS_DEF;
    localparam int CYCLE_LIMIT = 400000;
    localparam int HOLD_CYCLES = 250;
    localparam logic [APB_AW-1:0] ADDR_MAP = {REG_CHANNEL_MAP, 3'b000};
    localparam logic [APB_AW-1:0] ADDR_HOP = {REG_HOP_INCREMENT, 3'b000};

    typedef struct packed {
        logic [START_W-1:0] start;
        logic [MODE_W-1:0]  mode;
    } hop_req_t;

    typedef struct packed {
        logic             empty;
        logic [IDX_W-1:0] unmapped;
        logic [IDX_W-1:0] channel;
    } hop_res_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata = '0;  // [1:0] mode, [7:2] start_channel
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;       // [5:0] channel, [11:6] unmapped_index,
                                        // [12] map_empty, [15:13] zero
    logic                psel = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite = 1'b0;
    logic [APB_AW-1:0]   paddr = '0;
    logic [APB_DW-1:0]   pwdata = '0;
    logic [APB_DW-1:0]   prdata;
    logic                pready;

    // predictor state
    logic [NCH-1:0]   chan_map = '1;
    logic [HOP_W-1:0] hop_step = HOP_RESET;
    logic [IDX_W-1:0] cur_index = '0;

    hop_req_t pending_q[$];
    hop_res_t channel_q[$];
    hop_req_t offered;
    hop_res_t want;

    logic gaps_on = 1'b1;
    int   fail_count = 0;
    int   beats_in = 0;
    int   beats_out = 0;
    int   settings_used = 0;
    int   hold_left = 0;
    bit   hold_done = 0;
    int   cycles = 0;

    ble_csa1_hop_sequencer u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("== FAIL ==");
            $finish;
        end
    end

    function automatic hop_res_t next_hop(input hop_req_t req);
        hop_res_t r;
        int used;
        int slot;
        case (req.mode)
            MODE_ADVANCE: cur_index = IDX_W'((int'(cur_index) + int'(hop_step)) % NCH);
            MODE_ZERO:    cur_index = '0;
            MODE_LOAD:    cur_index = IDX_W'(int'(req.start) % NCH);
            default:      ;
        endcase
        used       = $countones(chan_map);
        r.unmapped = cur_index;
        r.channel  = cur_index;
        r.empty    = (used == 0);
        if (!chan_map[cur_index] && used != 0)
        begin
            slot = int'(cur_index) % used;
            for (int k = 0; k < NCH; k++)
            begin
                if (chan_map[k])
                begin
                    if (slot == 0)
                        r.channel = IDX_W'(k);
                    slot--;
                end
            end
        end
        return r;
    endfunction

    task automatic check_field(input string name, input int exp_v, input int got_v);
        if (exp_v != got_v)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, got_v);
            fail_count++;
        end
    endtask

    // sender
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                channel_q.push_back(next_hop(offered));
                beats_in++;
            end
            if (!s_tvalid || s_tready)
            begin
                if (pending_q.size() != 0 && !(gaps_on && $urandom_range(0, 99) < 14))
                begin
                    offered = pending_q.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= offered;
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // receiver and checker
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (channel_q.size() == 0)
                begin
                    $display("%0t: unexpected beat, expected none, actual %h", $time, m_tdata);
                    fail_count++;
                end
                else
                begin
                    want = channel_q.pop_front();
                    check_field("channel", want.channel, m_tdata[5:0]);
                    check_field("unmapped_index", want.unmapped, m_tdata[11:6]);
                    check_field("map_empty", want.empty, m_tdata[12]);
                    check_field("padding", 0, m_tdata[15:13]);
                end
                beats_out++;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else if (!hold_done && beats_out >= 600 && pending_q.size() > 40)
            begin
                hold_done = 1;
                hold_left = HOLD_CYCLES;
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= !(gaps_on && $urandom_range(0, 99) < 14);
            end
        end
    end

    task automatic cfg_write(input logic [APB_AW-1:0] addr, input logic [APB_DW-1:0] data);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr == ADDR_MAP)
        begin
            chan_map = data[NCH-1:0];
            settings_used++;
        end
        else
        begin
            hop_step = data[HOP_W-1:0];
        end
    endtask

    task automatic add_item(input logic [MODE_W-1:0] mode, input int start);
        hop_req_t req;
        req.mode  = mode;
        req.start = START_W'(start);
        pending_q.push_back(req);
    endtask

    task automatic drain();
        @(negedge clk);
        while (pending_q.size() != 0 || s_tvalid || channel_q.size() != 0)
            @(negedge clk);
        repeat (40) @(negedge clk);
    endtask

    function automatic logic [APB_DW-1:0] rand_map(input int kind);
        logic [APB_DW-1:0] w;
        w = {$urandom, $urandom};
        if (kind == 1)
        begin
            w[NCH-1:0] = '0;
            repeat ($urandom_range(1, 4)) w[$urandom_range(0, NCH - 1)] = 1'b1;
        end
        else if (kind == 2)
        begin
            w[NCH-1:0] = '1;
            repeat ($urandom_range(1, 4)) w[$urandom_range(0, NCH - 1)] = 1'b0;
        end
        return w;
    endfunction

    task automatic add_random(input int n);
        int r;
        repeat (n)
        begin
            r = $urandom_range(0, 99);
            if (r < 55)
                add_item(MODE_ADVANCE, $urandom_range(0, 63));
            else if (r < 70)
                add_item(MODE_QUERY, $urandom_range(0, 63));
            else if (r < 80)
                add_item(MODE_ZERO, $urandom_range(0, 63));
            else
                add_item(MODE_LOAD, $urandom_range(0, 63));
        end
    endtask

    initial
    begin
        logic [APB_DW-1:0] hop_word;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // reset settings: full map, hop of 5; start channel wrap
        @(negedge clk);
        add_item(MODE_QUERY, 0);
        add_item(MODE_ADVANCE, 0);
        add_item(MODE_ADVANCE, 63);
        add_item(MODE_LOAD, 36);
        add_item(MODE_ADVANCE, 0);
        add_item(MODE_LOAD, 37);
        add_item(MODE_LOAD, 63);
        add_item(MODE_ZERO, 63);
        drain();

        // two used channels, junk above the map, largest in-range hop
        cfg_write(ADDR_MAP, {27'h5A5A5A5, 37'h10_0000_0001});
        cfg_write(ADDR_HOP, 64'(16));
        @(negedge clk);
        add_item(MODE_LOAD, 1);
        add_item(MODE_ADVANCE, 0);
        add_item(MODE_ADVANCE, 0);
        add_item(MODE_LOAD, 36);
        add_item(MODE_ADVANCE, 0);
        add_item(MODE_ZERO, 0);
        drain();

        // empty map, hop of zero
        cfg_write(ADDR_MAP, 64'h0);
        cfg_write(ADDR_HOP, {59'h0, 5'd0});
        @(negedge clk);
        add_item(MODE_ADVANCE, 0);
        add_item(MODE_LOAD, 20);
        add_item(MODE_ADVANCE, 0);
        add_item(MODE_QUERY, 0);
        add_item(MODE_LOAD, 63);
        drain();

        // only the top channel used, hop of 31, all junk bits set
        cfg_write(ADDR_MAP, {27'h7FFFFFF, 37'h10_0000_0000});
        cfg_write(ADDR_HOP, {59'h7FF_FFFF_FFFF_FFFF, 5'd31});
        @(negedge clk);
        add_item(MODE_LOAD, 0);
        add_item(MODE_ADVANCE, 0);
        add_item(MODE_ADVANCE, 0);
        add_item(MODE_ADVANCE, 0);
        add_item(MODE_QUERY, 0);
        drain();

        for (int ph = 0; ph < 8; ph++)
        begin
            gaps_on <= (ph != 3);
            cfg_write(ADDR_MAP, rand_map(ph % 3));
            hop_word = {$urandom, $urandom};
            hop_word[HOP_W-1:0] = (ph % 2 == 0) ? HOP_W'($urandom_range(5, 16))
                                                : HOP_W'($urandom_range(0, 31));
            cfg_write(ADDR_HOP, hop_word);
            @(negedge clk);
            add_random(200);
            drain();
        end

        $display("%0d beats in, %0d checked, across %0d channel maps", beats_in, beats_out,
                 settings_used);
        $display("covered empty, sparse, dense and full maps, hop 0..31, long output stall");
        if (fail_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

[ble_csa1_hop_sequencer.f]
hdl/bcsa1_pkg.sv
hdl/ble_csa1_hop_sequencer.sv
hdl/bcsa1_checker.sv
dv/testbench.sv
